/* design/pcmfc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pcmfc_pkg
// types, constants and sample format functions of the pcm format and channel
// converter
// ----------------------------------------------------------------------------
package pcmfc_pkg;

    localparam int CMD_QUEUE_DEPTH = 4;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_FMT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT_FMT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_CH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT_CH  = 3'd3;

    localparam logic [1:0] CH_MONO   = 2'd1;
    localparam logic [1:0] CH_STEREO = 2'd2;

    typedef enum logic [2:0] {
        FMT_U8    = 3'd0,
        FMT_S8    = 3'd1,
        FMT_U16LE = 3'd2,
        FMT_U16BE = 3'd3,
        FMT_S16LE = 3'd4,
        FMT_S16BE = 3'd5
    } t_fmt;

    typedef enum logic [1:0] {
        KIND_ONE = 2'd0,
        KIND_DUP = 2'd1,
        KIND_AVG = 2'd2
    } t_kind;

    typedef struct packed {
        logic [15:0] sample_word;
        logic        block_end;
    } t_in_item;

    typedef struct packed {
        logic [15:0] out_word;
        logic        run_last;
    } t_out_item;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] held;
        logic [15:0] word;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    function automatic t_fmt fmt_norm(input logic [2:0] code);
        t_fmt f;
        case (code)
            FMT_U8:    f = FMT_U8;
            FMT_S8:    f = FMT_S8;
            FMT_U16LE: f = FMT_U16LE;
            FMT_U16BE: f = FMT_U16BE;
            FMT_S16BE: f = FMT_S16BE;
            default:   f = FMT_S16LE;
        endcase
        return f;
    endfunction

    function automatic logic [15:0] swap16(input logic [15:0] w);
        return {w[7:0], w[15:8]};
    endfunction

    // raw sample to 16 bit two's complement
    function automatic logic [15:0] decode(input logic [15:0] w, input t_fmt f);
        logic [15:0] v;
        case (f)
            FMT_U8:    v = {w[7:0] ^ 8'h80, 8'h00};
            FMT_S8:    v = {w[7:0], 8'h00};
            FMT_U16LE: v = w ^ 16'h8000;
            FMT_U16BE: v = swap16(w) ^ 16'h8000;
            FMT_S16BE: v = swap16(w);
            default:   v = w;
        endcase
        return v;
    endfunction

    // 16 bit two's complement to raw sample
    function automatic logic [15:0] encode(input logic [15:0] v, input t_fmt f);
        logic [15:0] w;
        case (f)
            FMT_U8:    w = {8'h00, v[15:8] ^ 8'h80};
            FMT_S8:    w = {8'h00, v[15:8]};
            FMT_U16LE: w = v ^ 16'h8000;
            FMT_U16BE: w = swap16(v ^ 16'h8000);
            FMT_S16BE: w = swap16(v);
            default:   w = v;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

/* design/pcmfc_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pcmfc_front
// configuration registers, format conversion, channel mode classification
// and stereo pair holding; issues commands to the back end
// ----------------------------------------------------------------------------
module pcmfc_front
    import pcmfc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_push,
    input  wire t_in_item              i_in,
    input  wire logic                  i_q_full,
    output logic                       o_full,
    output logic                       o_q_push,
    output t_cmd                       o_q_cmd,
    output t_fmt                       o_tgt_fmt
);

    logic [2:0]  r_src_fmt, n_src_fmt;
    logic [2:0]  r_tgt_fmt, n_tgt_fmt;
    logic [1:0]  r_src_ch, n_src_ch;
    logic [1:0]  r_tgt_ch, n_tgt_ch;
    logic        r_pair_pending, n_pair_pending;
    logic [15:0] r_pair_held, n_pair_held;
    logic        accept;
    logic        cfg_hit;
    logic        mode_dup;
    logic        mode_pair;
    logic [15:0] word;

    assign o_full    = i_q_full;
    assign accept    = i_push && !i_q_full;
    assign o_tgt_fmt = fmt_norm(r_tgt_fmt);
    assign word      = encode(decode(i_in.sample_word, fmt_norm(r_src_fmt)), o_tgt_fmt);
    assign mode_dup  = (r_src_ch == CH_MONO) && (r_tgt_ch == CH_STEREO);
    assign mode_pair = (r_src_ch == CH_STEREO) && (r_tgt_ch == CH_MONO);

    always_comb begin
        n_src_fmt = r_src_fmt;
        n_tgt_fmt = r_tgt_fmt;
        n_src_ch  = r_src_ch;
        n_tgt_ch  = r_tgt_ch;
        cfg_hit   = 1'b0;
        if (i_cfg_we) begin
            cfg_hit = 1'b1;
            case (i_cfg_idx)
                CFG_SRC_FMT: n_src_fmt = i_cfg_data;
                CFG_TGT_FMT: n_tgt_fmt = i_cfg_data;
                CFG_SRC_CH:  n_src_ch  = i_cfg_data[1:0];
                CFG_TGT_CH:  n_tgt_ch  = i_cfg_data[1:0];
                default:     cfg_hit   = 1'b0;
            endcase
        end
    end

    always_comb begin
        n_pair_pending = r_pair_pending;
        n_pair_held    = r_pair_held;
        o_q_push       = 1'b0;
        o_q_cmd.kind   = mode_dup ? KIND_DUP : (mode_pair ? KIND_AVG : KIND_ONE);
        o_q_cmd.held   = r_pair_held;
        o_q_cmd.word   = word;
        if (cfg_hit) begin
            n_pair_pending = 1'b0;
            n_pair_held    = 16'h0000;
        end else if (accept) begin
            if (mode_pair && !r_pair_pending) begin
                n_pair_pending = !i_in.block_end;
                n_pair_held    = i_in.block_end ? 16'h0000 : word;
            end else begin
                o_q_push = 1'b1;
                if (mode_pair) begin
                    n_pair_pending = 1'b0;
                    n_pair_held    = 16'h0000;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_fmt      <= 3'd0;
            r_tgt_fmt      <= 3'd0;
            r_src_ch       <= CH_STEREO;
            r_tgt_ch       <= CH_STEREO;
            r_pair_pending <= 1'b0;
            r_pair_held    <= 16'h0000;
        end else begin
            r_src_fmt      <= n_src_fmt;
            r_tgt_fmt      <= n_tgt_fmt;
            r_src_ch       <= n_src_ch;
            r_tgt_ch       <= n_tgt_ch;
            r_pair_pending <= n_pair_pending;
            r_pair_held    <= n_pair_held;
        end
    end

endmodule
`default_nettype wire

/* design/pcmfc_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pcmfc_queue
// small command queue between the front and back ends
// ----------------------------------------------------------------------------
module pcmfc_queue
    import pcmfc_pkg::*;
#(
    parameter int DEPTH = CMD_QUEUE_DEPTH
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_cmd    i_cmd,
    input  wire logic    i_pop,
    output t_cmd         o_cmd,
    output t_queue_status o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push;
    logic          do_pop;

    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_cmd          = r_mem[r_rd_ptr];
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

/* design/pcmfc_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pcmfc_back
// executes commands: pass-through, duplication, pair averaging and the result register
// ----------------------------------------------------------------------------
module pcmfc_back
    import pcmfc_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_fmt          i_tgt_fmt,
    input  wire t_cmd          i_cmd,
    input  wire t_queue_status i_q_status,
    output logic               o_q_pop,
    input  wire logic          i_pop,
    output logic               o_empty,
    output t_out_item          o_out
);

    function automatic logic signed [16:0] to_num(input logic [15:0] w, input t_fmt f);
        logic signed [16:0] n;
        case (f)
            FMT_U8:    n = {9'b0, w[7:0]};
            FMT_S8:    n = {{9{w[7]}}, w[7:0]};
            FMT_U16LE: n = {1'b0, w};
            FMT_U16BE: n = {1'b0, swap16(w)};
            FMT_S16BE: n = {w[7], swap16(w)};
            default:   n = {w[15], w};
        endcase
        return n;
    endfunction

    logic               r_valid, n_valid;
    logic               r_second, n_second;
    t_out_item          r_out;
    logic               out_free;
    logic               load;
    logic               pop_acc;
    logic               first_of_dup;
    logic signed [17:0] sum;
    logic signed [17:0] half;
    logic [15:0]        avg_word;

    assign sum  = 18'(to_num(i_cmd.held, i_tgt_fmt)) + 18'(to_num(i_cmd.word, i_tgt_fmt));
    assign half = (sum + 18'(sum[17])) >>> 1;

    always_comb begin
        case (i_tgt_fmt)
            FMT_U8, FMT_S8:       avg_word = {8'h00, half[7:0]};
            FMT_U16BE, FMT_S16BE: avg_word = swap16(half[15:0]);
            default:              avg_word = half[15:0];
        endcase
    end

    assign o_empty      = !r_valid;
    assign o_out        = r_out;
    assign pop_acc      = i_pop && r_valid;
    assign out_free     = !r_valid || pop_acc;
    assign load         = out_free && !i_q_status.empty;
    assign first_of_dup = (i_cmd.kind == KIND_DUP) && !r_second;
    assign o_q_pop      = load && !first_of_dup;

    always_comb begin
        n_valid  = r_valid;
        n_second = r_second;
        if (load) begin
            n_valid = 1'b1;
            if (i_cmd.kind == KIND_DUP) begin
                n_second = !r_second;
            end
        end else if (pop_acc) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.out_word <= (i_cmd.kind == KIND_AVG) ? avg_word : i_cmd.word;
            r_out.run_last <= !first_of_dup;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_second <= n_second;
        end
    end

endmodule
`default_nettype wire

/* design/pcm_format_and_channel_convert.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pcm_format_and_channel_convert
// converts pcm samples between 8/16 bit, signed/unsigned and byte orders,
// with mono to stereo duplication and stereo to mono averaging
// ----------------------------------------------------------------------------
// A transaction is accepted every cycle while full is low. Pass-through and
// stereo to mono modes sustain one input per cycle while results are popped;
// mono to stereo gives two results per input, so its input rate is set by the
// single result register that issues one result per cycle. A command queue of
// QUEUE_DEPTH entries decouples input from output; an input is queued, then
// loaded into the result register. Configuration writes are to be made
// only while idle, unchecked by the block; they clear any held stereo sample.
module pcm_format_and_channel_convert
    import pcmfc_pkg::*;
#(
    parameter int QUEUE_DEPTH = CMD_QUEUE_DEPTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  push,
    output logic                       full,
    input  wire t_in_item              i_in,
    output logic                       empty,
    input  wire logic                  pop,
    output t_out_item                  o_out
);

    logic          q_push;
    logic          q_pop;
    t_cmd          q_cmd_in;
    t_cmd          q_cmd_out;
    t_queue_status q_status;
    t_fmt          tgt_fmt;

    pcmfc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .i_in       (i_in),
        .i_q_full   (q_status.full),
        .o_full     (full),
        .o_q_push   (q_push),
        .o_q_cmd    (q_cmd_in),
        .o_tgt_fmt  (tgt_fmt)
    );

    pcmfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_cmd    (q_cmd_in),
        .i_pop    (q_pop),
        .o_cmd    (q_cmd_out),
        .o_status (q_status)
    );

    pcmfc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tgt_fmt  (tgt_fmt),
        .i_cmd      (q_cmd_out),
        .i_q_status (q_status),
        .o_q_pop    (q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out      (o_out)
    );

endmodule
`default_nettype wire
